// ===== src/iira_pkg.sv =====
// ----------------------------------------------------------------------------
// iira_pkg
// Shared codes and types for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iira_pkg;

	localparam int DATA_W   = 32;
	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 7;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	// request action codes
	localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_GET    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SET    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	// broadcast operation seen by every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== src/iira_req_if.sv =====
// ----------------------------------------------------------------------------
// iira_req_if
// Request channel: action, index and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iira_req_if;
	logic                                valid;
	logic                                ready;
	logic [iira_pkg::ACTION_W-1:0]       action;
	logic [iira_pkg::INDEX_W-1:0]        index;
	logic signed [iira_pkg::DATA_W-1:0]  value;

	modport source(output valid, output action, output index, output value, input ready);
	modport sink(input valid, input action, input index, input value, output ready);
endinterface

// ===== src/iira_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iira_rsp_if
// Result channel: read value, status and fill count with valid/ready.
// ----------------------------------------------------------------------------
interface iira_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [iira_pkg::DATA_W-1:0]  read_value;
	logic [iira_pkg::STATUS_W-1:0]       status;
	logic [iira_pkg::FILL_W-1:0]         fill_count;

	modport source(output valid, output read_value, output status, output fill_count,
		input ready);
	modport sink(input valid, input read_value, input status, input fill_count,
		output ready);
endinterface

// ===== src/iira_cell.sv =====
// ----------------------------------------------------------------------------
// iira_cell
// One array slot: takes a write, its left neighbor (insert) or its right
// neighbor (remove) depending on the broadcast command and its position.
// ----------------------------------------------------------------------------
module iira_cell #(
	parameter int WW  = 7,
	parameter int POS = 0
) (
	input  logic                                 clk,
	input  iira_pkg::cell_cmd_t                  cmd,
	input  logic [WW-1:0]                        target,
	input  logic [WW-1:0]                        rd_sel,
	input  logic signed [iira_pkg::DATA_W-1:0]   left,
	input  logic signed [iira_pkg::DATA_W-1:0]   right,
	output logic signed [iira_pkg::DATA_W-1:0]   data,
	output logic signed [iira_pkg::DATA_W-1:0]   rd_data
);

	localparam logic [WW-1:0] POS_W = WW'(POS);

	logic signed [iira_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			iira_pkg::CELL_WRITE: begin
				if (target == POS_W) data_q <= cmd.value;
			end
			iira_pkg::CELL_INS: begin
				if (target == POS_W) data_q <= cmd.value;
				else if (POS_W > target) data_q <= left;
			end
			iira_pkg::CELL_REM: begin
				if (POS_W >= target) data_q <= right;
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	// only the addressed cell drives the read bus
	assign rd_data = (rd_sel == POS_W) ? data_q : '0;

endmodule

// ===== src/indexed_insert_remove_array_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_top
// Ordered array of signed words with push, pop, get, set, insert, remove.
// ----------------------------------------------------------------------------
// The row of DEPTH cells shifts the entries from the index on up (insert) or
// down (remove) in the same edge that updates the fill count, and reads go
// through a per-cell select onto an OR bus. The result is held in an output
// register; a new request is taken whenever that register is empty or being
// drained, so the sustained rate is one transfer per cycle while results are
// taken. Errors (empty pop, index out of range, full) change nothing and
// return a zero read value. Entries are not cleared at reset.
module indexed_insert_remove_array_top #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	iira_req_if.sink   req,
	iira_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > iira_pkg::INDEX_W) ? CW : iira_pkg::INDEX_W;

	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic signed [iira_pkg::DATA_W-1:0] rd_value_q;
	logic [iira_pkg::STATUS_W-1:0]      status_q;
	logic [iira_pkg::FILL_W-1:0]        fill_q;

	logic                   fire;
	logic [WW-1:0]          idx_w;
	logic [WW-1:0]          cnt_w;
	logic [WW-1:0]          nxt_cnt;
	logic [WW-1:0]          target;
	logic [WW-1:0]          rd_sel;
	logic                   rd_en;
	logic                   full;
	iira_pkg::cell_op_t     op;
	logic [iira_pkg::STATUS_W-1:0] st;
	iira_pkg::cell_cmd_t    cmd;

	logic signed [iira_pkg::DATA_W-1:0] cell_data [DEPTH];
	logic signed [iira_pkg::DATA_W-1:0] cell_rd   [DEPTH];
	logic signed [iira_pkg::DATA_W-1:0] rd_bus;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign idx_w = WW'(req.index);
	assign cnt_w = WW'(cnt_q);
	assign full  = (cnt_q == CW'(DEPTH));

	always_comb begin
		op      = iira_pkg::CELL_HOLD;
		st      = iira_pkg::ST_OK;
		nxt_cnt = cnt_w;
		target  = idx_w;
		rd_sel  = idx_w;
		rd_en   = 1'b0;
		unique case (req.action)
			iira_pkg::ACT_PUSH: begin
				if (full) st = iira_pkg::ST_FULL;
				else begin
					op      = iira_pkg::CELL_WRITE;
					target  = cnt_w;
					nxt_cnt = cnt_w + WW'(1);
				end
			end
			iira_pkg::ACT_POP: begin
				if (cnt_q == '0) st = iira_pkg::ST_EMPTY;
				else begin
					nxt_cnt = cnt_w - WW'(1);
					rd_sel  = cnt_w - WW'(1);
					rd_en   = 1'b1;
				end
			end
			iira_pkg::ACT_GET: begin
				if (idx_w >= cnt_w) st = iira_pkg::ST_BOUNDS;
				else rd_en = 1'b1;
			end
			iira_pkg::ACT_SET: begin
				if (idx_w >= cnt_w) st = iira_pkg::ST_BOUNDS;
				else op = iira_pkg::CELL_WRITE;
			end
			iira_pkg::ACT_INSERT: begin
				if (idx_w > cnt_w) st = iira_pkg::ST_BOUNDS;
				else if (full) st = iira_pkg::ST_FULL;
				else begin
					op      = iira_pkg::CELL_INS;
					nxt_cnt = cnt_w + WW'(1);
				end
			end
			iira_pkg::ACT_REMOVE: begin
				if (idx_w >= cnt_w) st = iira_pkg::ST_BOUNDS;
				else begin
					op      = iira_pkg::CELL_REM;
					nxt_cnt = cnt_w - WW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.op    = fire ? op : iira_pkg::CELL_HOLD;
	assign cmd.value = req.value;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [iira_pkg::DATA_W-1:0] left_d;
		logic signed [iira_pkg::DATA_W-1:0] right_d;
		if (k == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[k+1];
		end
		iira_cell #(.WW(WW), .POS(k)) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.target (target),
			.rd_sel (rd_sel),
			.left   (left_d),
			.right  (right_d),
			.data   (cell_data[k]),
			.rd_data(cell_rd[k])
		);
	end

	always_comb begin
		rd_bus = '0;
		for (int k = 0; k < DEPTH; k++) rd_bus = rd_bus | cell_rd[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q       <= CW'(nxt_cnt);
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_value_q <= rd_en ? rd_bus : '0;
			status_q   <= st;
			fill_q     <= nxt_cnt[iira_pkg::FILL_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = rd_value_q;
	assign rsp.status     = status_q;
	assign rsp.fill_count = fill_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	a_err_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st != iira_pkg::ST_OK |=> cnt_q == $past(cnt_q))
		else $error("failed request changed fill count");

	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> fill_q == cnt_w[iira_pkg::FILL_W-1:0])
		else $error("reported fill count differs from state");

	a_err_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != iira_pkg::ST_OK |-> rd_value_q == '0)
		else $error("error result with nonzero read value");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.action == iira_pkg::ACT_PUSH && st == iira_pkg::ST_OK
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not grow the array");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed insert/remove array. A driver feeds
// requests from a backlog with random gaps; a shadow array predicts every
// result at request transfer and a monitor compares each result transfer
// against the oldest prediction. Stimulus walks the fill level between empty
// and full many times, with error cases, a no-gap stretch and a long output
// stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ARRAY_DEPTH    = 64;
	localparam int RAND_ITEMS     = 1100;
	localparam int IDLE_PCT       = 34;
	localparam int BURST_LO       = 500;
	localparam int BURST_HI       = 750;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int MAX_REPORTS    = 10;
	localparam int INDEX_MAX      = (1 << iira_pkg::INDEX_W) - 1;

	// action codes the block treats as no-ops
	localparam logic [iira_pkg::ACTION_W-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [iira_pkg::ACTION_W-1:0] ACT_RSVD7 = 3'd7;

	localparam logic signed [iira_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [iira_pkg::DATA_W-1:0] WORD_MIN = 32'sh80000000;

	typedef struct {
		logic [iira_pkg::ACTION_W-1:0]       action;
		logic [iira_pkg::INDEX_W-1:0]        index;
		logic signed [iira_pkg::DATA_W-1:0]  value;
	} array_req_t;

	typedef struct {
		logic signed [iira_pkg::DATA_W-1:0]  read_value;
		logic [iira_pkg::STATUS_W-1:0]       status;
		logic [iira_pkg::FILL_W-1:0]         fill_count;
	} array_rsp_t;

	logic clk;
	logic arst_n;

	iira_req_if req_ch();
	iira_rsp_if rsp_ch();

	indexed_insert_remove_array_top #(
		.DEPTH(ARRAY_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	array_req_t req_backlog[$];
	array_rsp_t due_results[$];

	// shadow copy of the array contents
	logic [iira_pkg::DATA_W-1:0] shadow_words[ARRAY_DEPTH];
	int                          shadow_fill = 0;

	// fill level as seen by the stimulus generator
	int plan_fill = 0;

	int mismatches = 0;
	int reqs_taken = 0;
	int rsp_xfers  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic array_rsp_t apply_array_action(input array_req_t r);
		array_rsp_t res;
		int idx;
		int k;
		idx = r.index;
		res.read_value = '0;
		res.status     = iira_pkg::ST_OK;
		case (r.action)
			iira_pkg::ACT_PUSH: begin
				if (shadow_fill >= ARRAY_DEPTH) begin
					res.status = iira_pkg::ST_FULL;
				end else begin
					shadow_words[shadow_fill] = r.value;
					shadow_fill++;
				end
			end
			iira_pkg::ACT_POP: begin
				if (shadow_fill == 0) begin
					res.status = iira_pkg::ST_EMPTY;
				end else begin
					shadow_fill--;
					res.read_value = shadow_words[shadow_fill];
				end
			end
			iira_pkg::ACT_GET: begin
				if (idx >= shadow_fill) res.status = iira_pkg::ST_BOUNDS;
				else res.read_value = shadow_words[idx];
			end
			iira_pkg::ACT_SET: begin
				if (idx >= shadow_fill) res.status = iira_pkg::ST_BOUNDS;
				else shadow_words[idx] = r.value;
			end
			iira_pkg::ACT_INSERT: begin
				// bounds check wins over full
				if (idx > shadow_fill) begin
					res.status = iira_pkg::ST_BOUNDS;
				end else if (shadow_fill >= ARRAY_DEPTH) begin
					res.status = iira_pkg::ST_FULL;
				end else begin
					for (k = shadow_fill; k > idx; k--) shadow_words[k] = shadow_words[k-1];
					shadow_words[idx] = r.value;
					shadow_fill++;
				end
			end
			iira_pkg::ACT_REMOVE: begin
				if (idx >= shadow_fill) begin
					res.status = iira_pkg::ST_BOUNDS;
				end else begin
					for (k = idx; k + 1 < shadow_fill; k++) shadow_words[k] = shadow_words[k+1];
					shadow_fill--;
				end
			end
			default: begin
			end
		endcase
		res.fill_count = shadow_fill[iira_pkg::FILL_W-1:0];
		return res;
	endfunction

	task automatic add_req(input logic [iira_pkg::ACTION_W-1:0] action, input int index,
		input logic signed [iira_pkg::DATA_W-1:0] value);
		array_req_t r;
		r.action = action;
		r.index  = index[iira_pkg::INDEX_W-1:0];
		r.value  = value;
		req_backlog.push_back(r);
		case (action)
			iira_pkg::ACT_PUSH:   if (plan_fill < ARRAY_DEPTH) plan_fill++;
			iira_pkg::ACT_POP:    if (plan_fill > 0) plan_fill--;
			iira_pkg::ACT_INSERT: if (index <= plan_fill && plan_fill < ARRAY_DEPTH) plan_fill++;
			iira_pkg::ACT_REMOVE: if (index < plan_fill) plan_fill--;
			default: begin
			end
		endcase
	endtask

	function automatic logic signed [iira_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly legal positions; upto_fill admits the append slot for insert
	function automatic int pick_index(input bit upto_fill);
		int top;
		top = upto_fill ? plan_fill : plan_fill - 1;
		if (top < 0 || $urandom_range(99) < 20) return $urandom_range(INDEX_MAX);
		return $urandom_range(top);
	endfunction

	task automatic build_random();
		bit draining;
		int r;
		int n;
		draining = 1'b0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (plan_fill == ARRAY_DEPTH && !draining && $urandom_range(3) == 0) draining = 1'b1;
			else if (plan_fill == 0 && draining && $urandom_range(3) == 0) draining = 1'b0;
			else if ($urandom_range(99) < 2) draining = !draining;
			r = $urandom_range(99);
			if (!draining) begin
				if (r < 40)
					add_req(iira_pkg::ACT_PUSH, $urandom_range(INDEX_MAX), pick_word());
				else if (r < 70)
					add_req(iira_pkg::ACT_INSERT, pick_index(1'b1), pick_word());
				else if (r < 80)
					add_req(iira_pkg::ACT_GET, pick_index(1'b0), $urandom);
				else if (r < 88)
					add_req(iira_pkg::ACT_SET, pick_index(1'b0), pick_word());
				else if (r < 93)
					add_req(iira_pkg::ACT_POP, $urandom_range(INDEX_MAX), $urandom);
				else if (r < 98)
					add_req(iira_pkg::ACT_REMOVE, pick_index(1'b0), $urandom);
				else add_req($urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7,
					$urandom_range(INDEX_MAX), $urandom);
			end else begin
				if (r < 35)
					add_req(iira_pkg::ACT_POP, $urandom_range(INDEX_MAX), $urandom);
				else if (r < 65)
					add_req(iira_pkg::ACT_REMOVE, pick_index(1'b0), $urandom);
				else if (r < 75)
					add_req(iira_pkg::ACT_GET, pick_index(1'b0), $urandom);
				else if (r < 83)
					add_req(iira_pkg::ACT_SET, pick_index(1'b0), pick_word());
				else if (r < 90)
					add_req(iira_pkg::ACT_PUSH, $urandom_range(INDEX_MAX), pick_word());
				else if (r < 97)
					add_req(iira_pkg::ACT_INSERT, pick_index(1'b1), pick_word());
				else add_req($urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7,
					$urandom_range(INDEX_MAX), $urandom);
			end
		end
	endtask

	// request driver: prediction is taken at the request transfer
	always @(posedge clk or negedge arst_n) begin
		array_req_t seen;
		array_req_t nxt;
		logic       holding;
		bit         in_burst;
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.action <= iira_pkg::ACT_PUSH;
			req_ch.index  <= '0;
			req_ch.value  <= '0;
		end else begin
			holding = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				seen.action = req_ch.action;
				seen.index  = req_ch.index;
				seen.value  = req_ch.value;
				due_results.push_back(apply_array_action(seen));
				reqs_taken++;
				holding = 1'b0;
			end
			in_burst = (reqs_taken >= BURST_LO) && (reqs_taken < BURST_HI);
			if (!holding) begin
				if (req_backlog.size() > 0 && (in_burst || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = req_backlog.pop_front();
					req_ch.valid  <= 1'b1;
					req_ch.action <= nxt.action;
					req_ch.index  <= nxt.index;
					req_ch.value  <= nxt.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: random gaps, one long hold-off, one no-gap stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) rsp_xfers++;
			if (!hold_done && rsp_xfers >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (rsp_xfers >= BURST_LO && rsp_xfers < BURST_HI) ||
					($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		array_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: read_value=%0d status=%0d fill_count=%0d",
						rsp_ch.read_value, rsp_ch.status, rsp_ch.fill_count);
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.read_value !== want.read_value || rsp_ch.status !== want.status ||
					rsp_ch.fill_count !== want.fill_count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: read_value %0d/%0d status %0d/%0d fill %0d/%0d (exp/got)",
							want.read_value, rsp_ch.read_value, want.status, rsp_ch.status,
							want.fill_count, rsp_ch.fill_count);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = iira_pkg::ACT_PUSH;
		req_ch.index  = '0;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;

		// empty-array errors
		add_req(iira_pkg::ACT_POP, 0, 0);
		add_req(iira_pkg::ACT_GET, 0, 0);
		add_req(iira_pkg::ACT_SET, 0, WORD_MAX);
		add_req(iira_pkg::ACT_REMOVE, 0, 0);
		add_req(iira_pkg::ACT_INSERT, 1, WORD_MAX);
		// insert at the end appends
		add_req(iira_pkg::ACT_INSERT, 0, WORD_MAX);
		add_req(iira_pkg::ACT_PUSH, INDEX_MAX, WORD_MIN);
		add_req(iira_pkg::ACT_PUSH, 0, -1);
		add_req(iira_pkg::ACT_INSERT, 1, 0);
		add_req(iira_pkg::ACT_INSERT, 4, 12345);
		add_req(iira_pkg::ACT_GET, 0, 0);
		add_req(iira_pkg::ACT_GET, 4, 0);
		add_req(iira_pkg::ACT_GET, 5, 0);
		add_req(iira_pkg::ACT_GET, INDEX_MAX, 0);
		add_req(iira_pkg::ACT_SET, 2, 32'sha5a5a5a5);
		add_req(iira_pkg::ACT_SET, INDEX_MAX, -1);
		add_req(iira_pkg::ACT_INSERT, INDEX_MAX, 7);
		add_req(iira_pkg::ACT_REMOVE, 1, 0);
		add_req(iira_pkg::ACT_REMOVE, INDEX_MAX, 0);
		add_req(ACT_RSVD6, INDEX_MAX, -1);
		add_req(ACT_RSVD7, 0, WORD_MIN);
		add_req(iira_pkg::ACT_GET, 2, 0);
		add_req(iira_pkg::ACT_POP, 0, 0);
		add_req(iira_pkg::ACT_REMOVE, 0, 0);
		build_random();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_ch.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (due_results.size() != 0)
			$display("%0d results never arrived", due_results.size());
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== indexed_insert_remove_array_top.f =====
src/iira_pkg.sv
src/iira_req_if.sv
src/iira_rsp_if.sv
src/iira_cell.sv
src/indexed_insert_remove_array_top.sv
tb/tb_top.sv
